// ----- src/tcrt_pkg.sv -----
package tcrt_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ALT_W   = 20;
	localparam int unsigned PIN_W   = 13;
	localparam int unsigned POUT_W  = 14;
	localparam int unsigned SPEED_W = 11;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned IDX_W   = 1;

	localparam int unsigned DVD_W   = 30;
	localparam int unsigned CNT_W   = 5;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [IDX_W-1:0] REG_CLIMB_LIMIT = 1'd0;
	localparam logic [IDX_W-1:0] REG_PILOT_LIMIT = 1'd1;

	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start_go;
		logic out_free;
	} dp_status_t;

endpackage

// ----- src/tcrt_ctrl.sv -----
module tcrt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tcrt_pkg::dp_status_t   status,
	output tcrt_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                 state_q;
	logic [tcrt_pkg::CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC) && (status.start_go || status.out_free);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (status.start_go) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tcrt_pkg::DIV_LAST) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/tcrt_dp.sv -----
module tcrt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tcrt_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tcrt_pkg::CFG_W-1:0]          cfg_data,
	input  logic [tcrt_pkg::CMD_W-1:0]          cmd_in,
	input  logic [tcrt_pkg::TIME_W-1:0]         now_ms,
	input  logic [tcrt_pkg::ALT_W-1:0]          target_alt,
	input  logic signed [tcrt_pkg::PIN_W-1:0]   pilot_rate_in,
	input  tcrt_pkg::ctrl_cmd_t                 ctl,
	output tcrt_pkg::dp_status_t                status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                takeoff_active,
	output logic [tcrt_pkg::SPEED_W-1:0]        takeoff_rate,
	output logic signed [tcrt_pkg::POUT_W-1:0]  pilot_rate_out
);

	localparam int unsigned SPEED_W = tcrt_pkg::SPEED_W;
	localparam int unsigned POUT_W  = tcrt_pkg::POUT_W;
	localparam int unsigned DVD_W   = tcrt_pkg::DVD_W;
	localparam int unsigned TIME_W  = tcrt_pkg::TIME_W;

	logic [tcrt_pkg::CFG_W-1:0] climb_lim_q;
	logic [tcrt_pkg::CFG_W-1:0] pilot_lim_q;

	logic [tcrt_pkg::CMD_W-1:0]        cmd_q;
	logic [TIME_W-1:0]                 now_q;
	logic [tcrt_pkg::ALT_W-1:0]        alt_q;
	logic signed [tcrt_pkg::PIN_W-1:0] pilot_q;

	logic               active_q;
	logic [SPEED_W-1:0] climb_speed_q;
	logic [TIME_W-1:0]  start_time_q;
	logic [TIME_W-1:0]  duration_q;

	logic [DVD_W-1:0]   dvd_q;
	logic [SPEED_W-1:0] rem_q;

	logic                      out_valid_q;
	logic                      out_active_q;
	logic [SPEED_W-1:0]        out_trate_q;
	logic signed [POUT_W-1:0]  out_prate_q;

	// climb speed from the limits
	logic [SPEED_W:0]   pv2;
	logic [27:0]        third_prod;
	logic [SPEED_W-1:0] two_thirds;
	logic [SPEED_W-1:0] pv_less50;
	logic [SPEED_W-1:0] mx;
	logic [SPEED_W-1:0] speed;

	always_comb begin
		pv2        = {pilot_lim_q, 1'b0};
		third_prod = 28'(pv2) * 28'd43691;
		two_thirds = third_prod[27:17];
		pv_less50  = pilot_lim_q - SPEED_W'(50);
		if (pilot_lim_q > SPEED_W'(50) && pv_less50 > two_thirds) mx = pv_less50;
		else mx = two_thirds;
		speed = (climb_lim_q < mx) ? climb_lim_q : mx;
	end

	assign status.start_go = (cmd_q == tcrt_pkg::CMD_START) && !active_q
		&& (speed != '0) && (alt_q != '0);
	assign status.out_free = !out_valid_q || out_ready;

	// divider step
	logic [SPEED_W:0]   rem_sh;
	logic               q_bit;
	logic [SPEED_W:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DVD_W-1]};
		rem_sub = rem_sh - {1'b0, climb_speed_q};
		q_bit   = (rem_sh >= {1'b0, climb_speed_q});
	end

	// query split
	logic [TIME_W-1:0]        elapsed;
	logic                     expired;
	logic signed [POUT_W-1:0] pilot_x;
	logic signed [POUT_W-1:0] sp_x;
	logic signed [POUT_W-1:0] sum;
	logic signed [POUT_W-1:0] diff;

	logic                     r_active;
	logic [SPEED_W-1:0]       r_trate;
	logic signed [POUT_W-1:0] r_prate;
	logic                     r_stop;

	always_comb begin
		elapsed = now_q - start_time_q;
		expired = (elapsed >= duration_q);
		pilot_x = POUT_W'(pilot_q);
		sp_x    = signed'({{(POUT_W-SPEED_W){1'b0}}, climb_speed_q});
		sum     = pilot_x + sp_x;
		diff    = pilot_x - sp_x;
		r_active = active_q;
		r_trate  = '0;
		r_prate  = '0;
		r_stop   = 1'b0;
		unique case (cmd_q)
			tcrt_pkg::CMD_STOP: begin
				r_active = 1'b0;
				r_stop   = 1'b1;
			end
			tcrt_pkg::CMD_QUERY: begin
				r_prate = pilot_x;
				if (active_q) begin
					if (expired) begin
						r_active = 1'b0;
						r_stop   = 1'b1;
					end else if (climb_speed_q != '0) begin
						if (pilot_q < 0) begin
							if (sum > 0) begin
								r_trate = sum[SPEED_W-1:0];
								r_prate = '0;
							end else begin
								r_prate = sum;
							end
						end else begin
							r_trate = climb_speed_q;
							r_prate = (pilot_x > sp_x) ? diff : '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			climb_lim_q <= tcrt_pkg::CFG_W'(250);
			pilot_lim_q <= tcrt_pkg::CFG_W'(250);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcrt_pkg::REG_CLIMB_LIMIT: climb_lim_q <= cfg_data;
				tcrt_pkg::REG_PILOT_LIMIT: pilot_lim_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_in;
			now_q   <= now_ms;
			alt_q   <= target_alt;
			pilot_q <= pilot_rate_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && status.start_go) begin
			dvd_q <= DVD_W'(alt_q) * DVD_W'(1000);
			rem_q <= '0;
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			climb_speed_q <= '0;
			start_time_q  <= '0;
			duration_q    <= '0;
		end else if (ctl.exec) begin
			if (status.start_go) begin
				climb_speed_q <= speed;
				start_time_q  <= now_q;
			end else begin
				active_q <= r_active;
				if (r_stop) start_time_q <= '0;
			end
		end else if (ctl.finish) begin
			active_q   <= 1'b1;
			duration_q <= TIME_W'(dvd_q);
		end
	end

	logic out_wr;
	assign out_wr = (ctl.exec && !status.start_go) || ctl.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			if (ctl.finish) begin
				out_active_q <= 1'b1;
				out_trate_q  <= '0;
				out_prate_q  <= '0;
			end else begin
				out_active_q <= r_active;
				out_trate_q  <= r_trate;
				out_prate_q  <= r_prate;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign takeoff_active = out_active_q;
	assign takeoff_rate   = out_trate_q;
	assign pilot_rate_out = out_prate_q;

endmodule

// ----- src/takeoff_climb_rate_timer_top.sv -----
// takeoff climb-rate timer
// input channel in_valid/in_ready carries one command word: cmd, now_ms,
// target_alt and pilot_rate_in. every word gives exactly one result word on
// out_valid/out_ready: takeoff_active, takeoff_rate, pilot_rate_out.
// climb_speed_limit (index 0) and pilot_vertical_limit (index 1) are written
// through cfg_we/cfg_index/cfg_data. the user must write them only while the
// block is idle; the block itself does not enforce this. one word is worked at
// a time: a stop, query or ignored start word moves from idle to exec, writes
// its result to the output register once that register is free, and returns
// to idle to take the next word. a start that arms the timer runs a restoring
// divider of target_alt*1000 by the climb speed, one quotient bit per cycle
// across the 30-bit dividend, then writes its result once the output is free.
// a finished result sits in an output register; the input still takes a new
// word while it waits, but that word's result is held back until the
// receiver takes the previous one.
// reset (arst_n low) clears the timer state, empties the output register and
// loads both limits with 250.
module takeoff_climb_rate_timer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tcrt_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tcrt_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tcrt_pkg::CMD_W-1:0]          cmd,
	input  logic [tcrt_pkg::TIME_W-1:0]         now_ms,
	input  logic [tcrt_pkg::ALT_W-1:0]          target_alt,
	input  logic signed [tcrt_pkg::PIN_W-1:0]   pilot_rate_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                takeoff_active,
	output logic [tcrt_pkg::SPEED_W-1:0]        takeoff_rate,
	output logic signed [tcrt_pkg::POUT_W-1:0]  pilot_rate_out
);

	tcrt_pkg::ctrl_cmd_t  ctl;
	tcrt_pkg::dp_status_t status;

	tcrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (ctl)
	);

	tcrt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd_in         (cmd),
		.now_ms         (now_ms),
		.target_alt     (target_alt),
		.pilot_rate_in  (pilot_rate_in),
		.ctl            (ctl),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.takeoff_active (takeoff_active),
		.takeoff_rate   (takeoff_rate),
		.pilot_rate_out (pilot_rate_out)
	);

endmodule
